// File: rtl/chacha20_keystream_generator_unit_assert.svh
// Assertion macros for the keystream generator
`ifndef CHACHA20_KEYSTREAM_GENERATOR_UNIT_ASSERT_SVH
`define CHACHA20_KEYSTREAM_GENERATOR_UNIT_ASSERT_SVH
// Check that cond holds in the same cycle as trig
`define CKG_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);
// Check that cond holds in the cycle after trig
`define CKG_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`endif

// File: rtl/ckg_pkg.sv
// Package: constants, types and helper functions of the keystream generator
package ckg_pkg;
  localparam int WORDS = 16;
  localparam int KEY_REGS = 4;
  localparam int BUF_BYTES = 64;
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646E;
  localparam logic [31:0] SIGMA2 = 32'h7962_2D32;
  localparam logic [31:0] SIGMA3 = 32'h6B20_6574;

  typedef logic [3:0] widx_t;
  typedef struct packed {
    widx_t a;
    widx_t b;
    widx_t c;
    widx_t d;
  } qr_sel_t;

  // Word indexes of quarter-round q: columns 0..3, diagonals 4..7
  function automatic qr_sel_t qr_sel(input logic [2:0] q);
    qr_sel_t s;
    logic [1:0] j;
    j = q[1:0];
    if (!q[2]) begin
      s.a = {2'b00, j};
      s.b = {2'b01, j};
      s.c = {2'b10, j};
      s.d = {2'b11, j};
    end else begin
      s.a = {2'b00, j};
      s.b = {2'b01, 2'(j + 2'd1)};
      s.c = {2'b10, 2'(j + 2'd2)};
      s.d = {2'b11, 2'(j + 2'd3)};
    end
    return s;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction
endpackage

// File: rtl/ckg_if.sv
// Channel interfaces: request, keystream result and key write
interface ckg_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] byte_count;
  modport source (output valid, output byte_count, input ready);
  modport sink (input valid, input byte_count, output ready);
endinterface

interface ckg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] keystream_byte;
  logic       last_byte;
  logic       exhausted;
  modport source (output valid, output keystream_byte, output last_byte, output exhausted,
                  input ready);
  modport sink (input valid, input keystream_byte, input last_byte, input exhausted,
                output ready);
endinterface

interface ckg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/chacha20_keystream_generator_unit.sv
// ChaCha keystream generator: byte requests in, keystream bytes out
// Channels: in_ch takes a request of byte_count bytes (0 gives nothing, above 64 means 64);
// out_ch returns one byte per item, last_byte on the final byte of the request and
// exhausted on all bytes of a request whose refill wraps the 128-bit block index.
// cfg_ch writes the four 64-bit key registers; it is always ready out of reset, the new
// key applies from the next refill, and buffered bytes stay.
// Sequence: one request at a time; each byte passes a position check, a buffer
// memory read, then the held output. A refill adds a load of the start block, then
// 8 * DOUBLE_ROUNDS quarter-rounds of two-port reads of the working-word memory, four
// update steps and four single-port writes each, then the final add into the buffer.
// If the buffer holds bytes, the first byte is valid after the position check and the
// buffer read (states S_CHK, S_RD) that follow the taken request.
// Reset: keys and block index go to zero and the buffer is marked empty, so the
// first request refills. A stalled receiver holds the byte on out_ch unchanged.
module chacha20_keystream_generator_unit
  import ckg_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  ckg_in_if.sink   in_ch,
  ckg_out_if.source out_ch,
  ckg_cfg_if.sink  cfg_ch
);
`include "chacha20_keystream_generator_unit_assert.svh"

  localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_INIT, S_QRD0, S_QRD1, S_QS0, S_QS1, S_QS2, S_QS3,
    S_QW0, S_QW1, S_QW2, S_QW3, S_FIN, S_RD, S_OUT
  } state_t;

  state_t           state_r;
  logic [63:0]      key_r [KEY_REGS];
  logic [127:0]     idx_r;
  logic [6:0]       pos_r;
  logic [6:0]       remain_r;
  logic             wrap_r;
  logic [4:0]       cnt_r;
  logic [2:0]       q_r;
  logic [RND_W-1:0] rnd_r;
  logic [31:0]      a_r, b_r, c_r, d_r;

  // working-word memory and block buffer (words of 4 bytes)
  logic [31:0] wmem [WORDS];
  logic [31:0] wrd0_r, wrd1_r;
  logic [31:0] bmem [WORDS];
  logic [31:0] brd_r;

  logic        w_we;
  widx_t       w_waddr, w_raddr0, w_raddr1;
  logic [31:0] w_wdata;
  logic        b_we, b_re;
  widx_t       b_waddr;
  logic [31:0] b_wdata;
  qr_sel_t     sel;
  logic [6:0]  req_n;
  logic [7:0]  pos_sum;
  widx_t       fin_idx;

  // start word of the block at index i
  function automatic logic [31:0] start_word(input widx_t i, input logic [63:0] k0,
                                             input logic [63:0] k1, input logic [63:0] k2,
                                             input logic [63:0] k3, input logic [127:0] ix);
    logic [31:0] w;
    case (i)
      4'd0:    w = SIGMA0;
      4'd1:    w = SIGMA1;
      4'd2:    w = SIGMA2;
      4'd3:    w = SIGMA3;
      4'd4:    w = k0[31:0];
      4'd5:    w = k0[63:32];
      4'd6:    w = k1[31:0];
      4'd7:    w = k1[63:32];
      4'd8:    w = k2[31:0];
      4'd9:    w = k2[63:32];
      4'd10:   w = k3[31:0];
      4'd11:   w = k3[63:32];
      4'd12:   w = ix[31:0];
      4'd13:   w = ix[63:32];
      4'd14:   w = ix[95:64];
      default: w = ix[127:96];
    endcase
    return w;
  endfunction

  assign sel     = qr_sel(q_r);
  assign req_n   = (in_ch.byte_count > 7'd64) ? 7'd64 : in_ch.byte_count;
  assign pos_sum = {1'b0, pos_r} + {1'b0, req_n};
  assign fin_idx = widx_t'(cnt_r - 5'd1);

  assign cfg_ch.ready = rst_n;
  assign in_ch.ready  = rst_n && (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.keystream_byte = 8'(brd_r >> {pos_r[1:0], 3'b000});
  assign out_ch.last_byte      = (remain_r == 7'd1);
  assign out_ch.exhausted      = wrap_r;

  // memory port control per state
  always_comb begin
    w_we     = 1'b0;
    w_waddr  = sel.a;
    w_wdata  = a_r;
    w_raddr0 = sel.a;
    w_raddr1 = sel.b;
    b_we     = 1'b0;
    b_waddr  = fin_idx;
    b_wdata  = wrd0_r + start_word(fin_idx, key_r[0], key_r[1], key_r[2], key_r[3], idx_r);
    b_re     = (state_r == S_RD);
    case (state_r)
      S_INIT: begin
        w_we    = 1'b1;
        w_waddr = cnt_r[3:0];
        w_wdata = start_word(cnt_r[3:0], key_r[0], key_r[1], key_r[2], key_r[3], idx_r);
      end
      S_QRD1: begin
        w_raddr0 = sel.c;
        w_raddr1 = sel.d;
      end
      S_QW0: w_we = 1'b1;
      S_QW1: begin
        w_we    = 1'b1;
        w_waddr = sel.b;
        w_wdata = b_r;
      end
      S_QW2: begin
        w_we    = 1'b1;
        w_waddr = sel.c;
        w_wdata = c_r;
      end
      S_QW3: begin
        w_we    = 1'b1;
        w_waddr = sel.d;
        w_wdata = d_r;
      end
      S_FIN: begin
        w_raddr0 = cnt_r[3:0];
        b_we     = (cnt_r != 5'd0);
      end
      default: ;
    endcase
  end

  // working-word memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    wrd0_r <= wmem[w_raddr0];
    wrd1_r <= wmem[w_raddr1];
  end

  // block buffer: one write, one registered read held while idle
  always_ff @(posedge clk) begin
    if (b_we) bmem[b_waddr] <= b_wdata;
    if (b_re) brd_r <= bmem[pos_r[5:2]];
  end

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) key_r[i] <= '0;
    end else if (cfg_ch.valid) begin
      key_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      pos_r    <= 7'd64;
      remain_r <= '0;
      wrap_r   <= 1'b0;
      cnt_r    <= '0;
      q_r      <= '0;
      rnd_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && (in_ch.byte_count != 7'd0)) begin
            remain_r <= req_n;
            wrap_r   <= (pos_sum > 8'd64) && (&idx_r);
            state_r  <= S_CHK;
          end
        end
        S_CHK: begin
          cnt_r   <= '0;
          q_r     <= '0;
          rnd_r   <= '0;
          state_r <= pos_r[6] ? S_INIT : S_RD;
        end
        S_INIT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) state_r <= S_QRD0;
        end
        S_QRD0: state_r <= S_QRD1;
        S_QRD1: begin
          a_r     <= wrd0_r;
          b_r     <= wrd1_r;
          state_r <= S_QS0;
        end
        S_QS0: begin
          a_r     <= a_r + b_r;
          d_r     <= rotl(wrd1_r ^ (a_r + b_r), 16);
          c_r     <= wrd0_r;
          state_r <= S_QS1;
        end
        S_QS1: begin
          c_r     <= c_r + d_r;
          b_r     <= rotl(b_r ^ (c_r + d_r), 12);
          state_r <= S_QS2;
        end
        S_QS2: begin
          a_r     <= a_r + b_r;
          d_r     <= rotl(d_r ^ (a_r + b_r), 8);
          state_r <= S_QS3;
        end
        S_QS3: begin
          c_r     <= c_r + d_r;
          b_r     <= rotl(b_r ^ (c_r + d_r), 7);
          state_r <= S_QW0;
        end
        S_QW0: state_r <= S_QW1;
        S_QW1: state_r <= S_QW2;
        S_QW2: state_r <= S_QW3;
        S_QW3: begin
          q_r <= q_r + 3'd1;
          if (q_r == 3'd7) begin
            rnd_r <= rnd_r + RND_W'(1);
            if (rnd_r == RND_W'(DOUBLE_ROUNDS - 1)) begin
              cnt_r   <= '0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_QRD0;
            end
          end else begin
            state_r <= S_QRD0;
          end
        end
        S_FIN: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            idx_r   <= idx_r + 128'd1;
            pos_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_OUT;
        S_OUT: begin
          if (out_ch.ready) begin
            pos_r    <= pos_r + 7'd1;
            remain_r <= remain_r - 7'd1;
            state_r  <= (remain_r == 7'd1) ? S_IDLE : S_CHK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CKG_ASSERT_NOW(a_out_filled, out_ch.valid, !pos_r[6], "byte shown from empty buffer")
  `CKG_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= 7'd64, "buffer position out of range")
  `CKG_ASSERT_NEXT(a_last_idle, out_ch.valid && out_ch.ready && out_ch.last_byte,
                   state_r == S_IDLE, "request not closed after last byte")
endmodule

// File: tb/tb_chacha20_keystream_generator_unit.sv
// Testbench of the ChaCha keystream generator: byte requests checked against a local predictor
`timescale 1ns / 100ps

module tb_chacha20_keystream_generator_unit;
  import ckg_pkg::*;

  localparam int ROUND_PAIRS = 10;
  localparam int SETTLE_CYCLES = 40;

  // Cfg register indexes
  typedef enum logic [1:0] {
    KEY_W01 = 2'd0,
    KEY_W23 = 2'd1,
    KEY_W45 = 2'd2,
    KEY_W67 = 2'd3
  } key_reg_e;

  typedef struct packed {
    logic [7:0] kbyte;
    logic       last;
    logic       exh;
  } ks_byte_t;

  logic clk;
  logic rst_n;

  ckg_in_if  in_ch ();
  ckg_out_if out_ch ();
  ckg_cfg_if cfg_ch ();

  chacha20_keystream_generator_unit #(
    .DOUBLE_ROUNDS(ROUND_PAIRS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor state
  logic [31:0] pred_key [8];
  logic [31:0] pred_ctr;
  logic [31:0] pred_nonce [3];
  logic [7:0]  pred_buf [64];
  int          pred_pos;
  logic [31:0] mix_w [16];

  ks_byte_t expected_bytes[$];
  int       error_count;
  bit       quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
    rot_left = (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rot_left(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rot_left(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rot_left(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rot_left(mix_w[b] ^ mix_w[c], 7);
  endfunction

  // Compute the next block into the buffer, advance the index, return 1 on wrap
  function automatic bit refill_block();
    logic [31:0] init_w [16];
    logic [31:0] sum;
    bit carry;
    init_w[0] = 32'h6170_7865;
    init_w[1] = 32'h3320_646E;
    init_w[2] = 32'h7962_2D32;
    init_w[3] = 32'h6B20_6574;
    for (int i = 0; i < 8; i++) init_w[4 + i] = pred_key[i];
    init_w[12] = pred_ctr;
    for (int i = 0; i < 3; i++) init_w[13 + i] = pred_nonce[i];
    for (int i = 0; i < 16; i++) mix_w[i] = init_w[i];
    for (int r = 0; r < ROUND_PAIRS; r++) begin
      quarter(0, 4, 8, 12); quarter(1, 5, 9, 13);
      quarter(2, 6, 10, 14); quarter(3, 7, 11, 15);
      quarter(0, 5, 10, 15); quarter(1, 6, 11, 12);
      quarter(2, 7, 8, 13); quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      sum = mix_w[i] + init_w[i];
      for (int k = 0; k < 4; k++) pred_buf[4 * i + k] = sum[8 * k +: 8];
    end
    pred_ctr = pred_ctr + 32'd1;
    carry = (pred_ctr == 32'd0);
    for (int i = 0; i < 3; i++) begin
      if (carry) begin
        pred_nonce[i] = pred_nonce[i] + 32'd1;
        carry = (pred_nonce[i] == 32'd0);
      end
    end
    pred_pos = 0;
    return carry;
  endfunction

  // Queue the bytes one request yields
  function automatic void predict_request(input logic [6:0] count);
    ks_byte_t req_bytes[$];
    ks_byte_t b;
    int n;
    bit wrapped;
    wrapped = 1'b0;
    n = (count > 7'd64) ? 64 : int'(count);
    for (int k = 0; k < n; k++) begin
      if (pred_pos >= 64) begin
        if (refill_block()) wrapped = 1'b1;
      end
      b.kbyte = pred_buf[pred_pos];
      b.last = (k == n - 1);
      b.exh = 1'b0;
      req_bytes.push_back(b);
      pred_pos++;
    end
    foreach (req_bytes[i]) begin
      req_bytes[i].exh = wrapped;
      expected_bytes.push_back(req_bytes[i]);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Check each accepted byte against the oldest expectation
  always @(posedge clk) begin
    ks_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_ch.keystream_byte, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.keystream_byte !== want.kbyte)
          report_mismatch("keystream_byte", out_ch.keystream_byte, want.kbyte);
        if (out_ch.last_byte !== want.last)
          report_mismatch("last_byte", 8'(out_ch.last_byte), 8'(want.last));
        if (out_ch.exhausted !== want.exh)
          report_mismatch("exhausted", 8'(out_ch.exhausted), 8'(want.exh));
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Send one request, with an optional idle burst ahead of it
  task automatic send_request(input logic [6:0] count);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_count <= count;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(count);
  endtask

  task automatic write_key(input key_reg_e idx, input logic [63:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    pred_key[2 * idx] = value[31:0];
    pred_key[2 * idx + 1] = value[63:32];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop the request, hold until every expected byte is in, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_keys(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
    wait_idle();
    write_key(KEY_W01, k0);
    write_key(KEY_W23, k1);
    write_key(KEY_W45, k2);
    write_key(KEY_W67, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [6:0] rand_count();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 7'd0;
    if (sel == 1) return 7'($urandom_range(65, 127));
    if (sel < 6) return 7'($urandom_range(1, 4));
    return 7'($urandom_range(1, 64));
  endfunction

  // Extremes of the count: full, single byte, zero, oversized, buffer straddles
  task automatic test_counts();
    send_request(7'd1);
    send_request(7'd64);
    send_request(7'd0);
    send_request(7'd63);
    send_request(7'd127);
    send_request(7'd65);
    send_request(7'd2);
    send_request(7'd0);
    send_request(7'd64);
    send_request(7'd100);
  endtask

  // Key extremes, and a key change with bytes still buffered
  task automatic test_key_change();
    load_keys('1, '1, '1, '1);
    send_request(7'd10);
    send_request(7'd64);
    load_keys(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
              64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    send_request(7'd60);
    send_request(7'd8);
    load_keys('0, '0, '0, '0);
    send_request(7'd33);
    send_request(7'd31);
    send_request(7'd1);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_request(rand_count());
  endtask

  initial begin
    error_count = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int i = 0; i < 8; i++) pred_key[i] = '0;
    for (int i = 0; i < 3; i++) pred_nonce[i] = '0;
    pred_ctr = '0;
    pred_pos = 64;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_counts();
    test_key_change();
    for (int p = 0; p < 3; p++) begin
      load_keys(rand64(), rand64(), rand64(), rand64());
      test_random(65);
    end
    wait_idle();
    quiet = 1'b1;
    test_random(65);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_idle();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
